// ===== src/qpsh_pkg.sv =====
// shared constants for the quadrature position and speed counter with homing
package qpsh_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned VALUE_W = 40;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned APB_W   = 32;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [CFG_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [CFG_W-1:0] UM_RST     = 16'd1257;
  localparam logic [CFG_W-1:0] SCALE_RST  = 16'd1257;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_UM     = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd3;

  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_SPEED  = 1'b1;

  localparam logic [CODE_W-1:0] MOTION_STOP = 2'd0;
  localparam logic [CODE_W-1:0] MOTION_POS  = 2'd1;
  localparam logic [CODE_W-1:0] MOTION_NEG  = 2'd2;

endpackage

// ===== src/quadrature_position_speed_with_homing.sv =====
// quadrature edge counter with end-stop homing, rope length and speed reports
//
//   channel   direction  carries
//   s_axis    in         tuser: req_type; tdata: level_a, level_b
//   m_axis    out        tuser: report_kind; tdata: report_value, pulse_total, motion_code
//   apb       in/out     period_ms, um_per_pulse, speed_scale
//
// one item per cycle while s_axis_tready_o is high; a report is captured in the operand
// stage with the state update, then passes the multiply and clamp stage into the result register
// reset clears the count, the phase, the window timer and both valid bits
// a stalled m_axis holds the result register; s_axis keeps taking items
// until the operand stage also fills
module quadrature_position_speed_with_homing #(
  parameter int unsigned COUNT_BITS = qpsh_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [qpsh_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // level_a, level_b, pad
  input  logic [qpsh_pkg::REQ_W-1:0]          s_axis_tuser_i,  // req_type
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [qpsh_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,  // report_value, pulse_total,
                                                               // motion_code, pad
  output logic                                m_axis_tuser_o,  // report_kind
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qpsh_pkg::ADDR_W-1:0]         paddr,
  input  logic [qpsh_pkg::APB_W-1:0]          pwdata,
  output logic [qpsh_pkg::APB_W-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned CW = qpsh_pkg::CFG_W;
  localparam int unsigned PW = COUNT_BITS + 1 + CW + 1;

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]        CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [63:0] VAL_MAX = 64'sd549755813887;
  localparam logic signed [63:0] VAL_MIN = -64'sd549755813888;
  localparam logic signed [32:0] TOT_MAX = 33'sd8388607;
  localparam logic signed [32:0] TOT_MIN = -33'sd8388608;

  // configuration
  logic [CW-1:0] period_q, um_q, scale_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= qpsh_pkg::PERIOD_RST;
      um_q     <= qpsh_pkg::UM_RST;
      scale_q  <= qpsh_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        qpsh_pkg::REG_PERIOD: period_q <= pwdata[CW-1:0];
        qpsh_pkg::REG_UM:     um_q     <= pwdata[CW-1:0];
        qpsh_pkg::REG_SCALE:  scale_q  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      qpsh_pkg::REG_PERIOD: prdata = {{(qpsh_pkg::APB_W-CW){1'b0}}, period_q};
      qpsh_pkg::REG_UM:     prdata = {{(qpsh_pkg::APB_W-CW){1'b0}}, um_q};
      qpsh_pkg::REG_SCALE:  prdata = {{(qpsh_pkg::APB_W-CW){1'b0}}, scale_q};
      default:              prdata = '0;
    endcase
  end

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q;
  logic out_load, accept;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_load;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // counter state
  logic signed [COUNT_BITS-1:0] count_q, count_d;
  logic [1:0]                   phase_q, phase_d;
  logic [CW-1:0]                ms_q, ms_d;

  logic [qpsh_pkg::REQ_W-1:0] req;
  logic                       lvl_a, lvl_b;
  logic [CW-1:0]              per;
  logic [CW:0]                ms_inc;
  logic                       report, rep_kind;

  assign req    = s_axis_tuser_i;
  assign lvl_a  = s_axis_tdata_i[0];
  assign lvl_b  = s_axis_tdata_i[1];
  assign per    = (period_q == '0) ? {{(CW-1){1'b0}}, 1'b1} : period_q;
  assign ms_inc = {1'b0, ms_q} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    count_d  = count_q;
    phase_d  = phase_q;
    ms_d     = ms_q;
    report   = 1'b0;
    rep_kind = qpsh_pkg::KIND_SPEED;
    if (accept) begin
      unique case (req)
        qpsh_pkg::REQ_EDGE: begin
          if (lvl_a == lvl_b) begin
            if (count_q != CNT_MIN) count_d = count_q - CNT_ONE;
          end else begin
            if (count_q != CNT_MAX) count_d = count_q + CNT_ONE;
          end
        end
        qpsh_pkg::REQ_TICK: begin
          if (phase_q != PH_WAIT && phase_q != PH_ARMED) begin
            if (ms_inc < {1'b0, per}) begin
              ms_d = ms_inc[CW-1:0];
            end else begin
              report  = 1'b1;
              count_d = '0;
              ms_d    = '0;
            end
          end
        end
        qpsh_pkg::REQ_FIRST: begin
          if (phase_q == PH_WAIT) begin
            count_d = '0;
            phase_d = PH_ARMED;
          end
        end
        default: begin
          if (phase_q == PH_ARMED) begin
            report   = 1'b1;
            rep_kind = qpsh_pkg::KIND_LENGTH;
            count_d  = '0;
            ms_d     = '0;
            phase_d  = PH_RUN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= PH_WAIT;
      ms_q    <= '0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      ms_q    <= ms_d;
    end
  end

  // operand stage
  logic                         s1_kind_q;
  logic signed [COUNT_BITS-1:0] s1_count_q;
  logic signed [COUNT_BITS:0]   s1_opnd_q;
  logic [CW-1:0]                s1_mult_q;
  logic [qpsh_pkg::CODE_W-1:0]  s1_code_q;
  logic signed [COUNT_BITS:0]   cnt_ext;
  logic [qpsh_pkg::CODE_W-1:0]  code_d;

  assign cnt_ext = {count_q[COUNT_BITS-1], count_q};

  always_comb begin
    if (rep_kind == qpsh_pkg::KIND_LENGTH || count_q == '0) begin
      code_d = qpsh_pkg::MOTION_STOP;
    end else if (count_q[COUNT_BITS-1]) begin
      code_d = qpsh_pkg::MOTION_NEG;
    end else begin
      code_d = qpsh_pkg::MOTION_POS;
    end
  end

  assign s1_valid_d = s_axis_tready_o ? (accept && report) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && report) begin
      s1_kind_q  <= rep_kind;
      s1_count_q <= count_q;
      s1_opnd_q  <= (rep_kind == qpsh_pkg::KIND_LENGTH && count_q[COUNT_BITS-1]) ?
                    -cnt_ext : cnt_ext;
      s1_mult_q  <= (rep_kind == qpsh_pkg::KIND_LENGTH) ? um_q : scale_q;
      s1_code_q  <= code_d;
    end
  end

  // multiply and clamp
  logic signed [CW:0]    mult_s;
  logic signed [PW-1:0]  prod;
  logic signed [63:0]    prod_ext;
  logic signed [32:0]    tot_ext;
  logic [qpsh_pkg::VALUE_W-1:0] value_c;
  logic [qpsh_pkg::TOTAL_W-1:0] total_c;

  assign mult_s   = {1'b0, s1_mult_q};
  assign prod     = s1_opnd_q * mult_s;
  assign prod_ext = {{(64-PW){prod[PW-1]}}, prod};
  assign tot_ext  = {{(33-COUNT_BITS){s1_count_q[COUNT_BITS-1]}}, s1_count_q};

  always_comb begin
    if (prod_ext > VAL_MAX) begin
      value_c = VAL_MAX[qpsh_pkg::VALUE_W-1:0];
    end else if (prod_ext < VAL_MIN) begin
      value_c = VAL_MIN[qpsh_pkg::VALUE_W-1:0];
    end else begin
      value_c = prod_ext[qpsh_pkg::VALUE_W-1:0];
    end
    if (tot_ext > TOT_MAX) begin
      total_c = TOT_MAX[qpsh_pkg::TOTAL_W-1:0];
    end else if (tot_ext < TOT_MIN) begin
      total_c = TOT_MIN[qpsh_pkg::TOTAL_W-1:0];
    end else begin
      total_c = tot_ext[qpsh_pkg::TOTAL_W-1:0];
    end
  end

  // result register
  logic                         out_kind_q;
  logic [qpsh_pkg::VALUE_W-1:0] out_value_q;
  logic [qpsh_pkg::TOTAL_W-1:0] out_total_q;
  logic [qpsh_pkg::CODE_W-1:0]  out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_kind_q  <= s1_kind_q;
      out_value_q <= value_c;
      out_total_q <= total_c;
      out_code_q  <= s1_code_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {{(qpsh_pkg::OUT_DATA_W - qpsh_pkg::VALUE_W - qpsh_pkg::TOTAL_W
                              - qpsh_pkg::CODE_W){1'b0}},
                            out_code_q, out_total_q, out_value_q};

  // checks
  a_len_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == qpsh_pkg::KIND_LENGTH |-> out_code_q == qpsh_pkg::MOTION_STOP)
    else $error("length report with nonzero motion code");

  a_pos_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_code_q == qpsh_pkg::MOTION_POS |->
      !out_total_q[qpsh_pkg::TOTAL_W-1] && out_total_q != '0)
    else $error("positive motion code with non-positive total");

  a_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req == qpsh_pkg::REQ_SECOND && phase_q == PH_ARMED |=>
      phase_q == PH_RUN && ms_q == '0 && s1_valid_q)
    else $error("armed second end-stop did not start running mode");

  a_ms_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WAIT || phase_q == PH_ARMED |-> ms_q == '0)
    else $error("window timer moved before running mode");

endmodule

// ===== tb/quadrature_report_checker.sv =====
// checker for the quadrature counter: predicts reports from accepted transfers, checks readbacks
module quadrature_report_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [qpsh_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // level_a, level_b, pad
  input  logic [qpsh_pkg::REQ_W-1:0]      s_axis_tuser_i,   // req_type
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [qpsh_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,   // report_value, pulse_total,
                                                            // motion_code, pad
  input  logic                            m_axis_tuser_i,   // report_kind
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [qpsh_pkg::ADDR_W-1:0]     paddr_i,
  input  logic [qpsh_pkg::APB_W-1:0]      pwdata_i,
  input  logic [qpsh_pkg::APB_W-1:0]      prdata_i,
  input  logic                            pready_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              compared_o,
  output int                              accepted_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HOME_WAIT, HOME_ARMED, RUNNING} homing_phase_e;

  typedef struct packed {
    logic                         kind;
    logic [qpsh_pkg::VALUE_W-1:0] value;
    logic [qpsh_pkg::TOTAL_W-1:0] total;
    logic [qpsh_pkg::CODE_W-1:0]  code;
  } report_t;

  localparam longint COUNT_MAX = (longint'(1) <<< (qpsh_pkg::COUNT_BITS_DEF - 1)) - 1;
  localparam longint VALUE_MAX = (longint'(1) <<< (qpsh_pkg::VALUE_W - 1)) - 1;
  localparam longint TOTAL_MAX = (longint'(1) <<< (qpsh_pkg::TOTAL_W - 1)) - 1;

  logic [qpsh_pkg::CFG_W-1:0] period_ms;
  logic [qpsh_pkg::CFG_W-1:0] um_per_pulse;
  logic [qpsh_pkg::CFG_W-1:0] speed_scale;
  longint                     edge_total;
  homing_phase_e              homing;
  int unsigned                window_ms;
  report_t                    expected_reports[$];
  int                         fails = 0;
  int                         compared = 0;
  int                         accepted = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic report_t make_report(logic kind, longint value, longint total,
                                          logic [qpsh_pkg::CODE_W-1:0] code);
    longint  v;
    longint  t;
    report_t r;
    v = clamp(value, -VALUE_MAX - 1, VALUE_MAX);
    t = clamp(total, -TOTAL_MAX - 1, TOTAL_MAX);
    r.kind  = kind;
    r.value = v[qpsh_pkg::VALUE_W-1:0];
    r.total = t[qpsh_pkg::TOTAL_W-1:0];
    r.code  = code;
    return r;
  endfunction

  task automatic note_failure(string msg);
    fails++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic predict_item(logic [qpsh_pkg::REQ_W-1:0] req, logic a, logic b);
    int unsigned                 per;
    longint                      mag;
    logic [qpsh_pkg::CODE_W-1:0] code;
    case (req)
      qpsh_pkg::REQ_EDGE: begin
        edge_total = clamp(edge_total + ((a == b) ? -1 : 1), -COUNT_MAX - 1, COUNT_MAX);
      end
      qpsh_pkg::REQ_TICK: begin
        if (homing == RUNNING) begin
          per = (period_ms == 0) ? 1 : period_ms;
          if (window_ms + 1 < per) begin
            window_ms = (window_ms + 1) & 16'hffff;
          end else begin
            code = (edge_total == 0) ? qpsh_pkg::MOTION_STOP :
                   (edge_total > 0) ? qpsh_pkg::MOTION_POS : qpsh_pkg::MOTION_NEG;
            expected_reports.push_back(make_report(qpsh_pkg::KIND_SPEED,
              edge_total * longint'({48'b0, speed_scale}), edge_total, code));
            edge_total = 0;
            window_ms  = 0;
          end
        end
      end
      qpsh_pkg::REQ_FIRST: begin
        if (homing == HOME_WAIT) begin
          edge_total = 0;
          homing     = HOME_ARMED;
        end
      end
      qpsh_pkg::REQ_SECOND: begin
        if (homing == HOME_ARMED) begin
          mag = (edge_total < 0) ? -edge_total : edge_total;
          expected_reports.push_back(make_report(qpsh_pkg::KIND_LENGTH,
            mag * longint'({48'b0, um_per_pulse}), edge_total, qpsh_pkg::MOTION_STOP));
          edge_total = 0;
          window_ms  = 0;
          homing     = RUNNING;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_report(report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      note_failure($sformatf("unexpected report kind %0d value %0d total %0d", got.kind,
                             $signed(got.value), $signed(got.total)));
      return;
    end
    want = expected_reports.pop_front();
    compared++;
    if (got.kind !== want.kind)
      note_failure($sformatf("report_kind got %0d expected %0d", got.kind, want.kind));
    if (got.value !== want.value)
      note_failure($sformatf("report_value got %0d expected %0d", $signed(got.value),
                             $signed(want.value)));
    if (got.total !== want.total)
      note_failure($sformatf("pulse_total got %0d expected %0d", $signed(got.total),
                             $signed(want.total)));
    if (got.code !== want.code)
      note_failure($sformatf("motion_code got %0d expected %0d", got.code, want.code));
  endtask

  task automatic check_readback(logic [1:0] idx);
    logic [qpsh_pkg::CFG_W-1:0] held;
    case (idx)
      qpsh_pkg::REG_PERIOD: held = period_ms;
      qpsh_pkg::REG_UM:     held = um_per_pulse;
      qpsh_pkg::REG_SCALE:  held = speed_scale;
      default:              return;
    endcase
    if (prdata_i !== {{(qpsh_pkg::APB_W - qpsh_pkg::CFG_W){1'b0}}, held})
      note_failure($sformatf("register %0d read %0h expected %0h", idx, prdata_i, held));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ms    = qpsh_pkg::PERIOD_RST;
      um_per_pulse = qpsh_pkg::UM_RST;
      speed_scale  = qpsh_pkg::SCALE_RST;
      edge_total   = 0;
      homing       = HOME_WAIT;
      window_ms    = 0;
      expected_reports.delete();
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[3:2])
            qpsh_pkg::REG_PERIOD: period_ms    = pwdata_i[qpsh_pkg::CFG_W-1:0];
            qpsh_pkg::REG_UM:     um_per_pulse = pwdata_i[qpsh_pkg::CFG_W-1:0];
            qpsh_pkg::REG_SCALE:  speed_scale  = pwdata_i[qpsh_pkg::CFG_W-1:0];
            default: begin
            end
          endcase
        end else begin
          check_readback(paddr_i[3:2]);
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_report('{kind: m_axis_tuser_i, value: m_axis_tdata_i[39:0],
                       total: m_axis_tdata_i[63:40], code: m_axis_tdata_i[65:64]});
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        accepted++;
        predict_item(s_axis_tuser_i, s_axis_tdata_i[0], s_axis_tdata_i[1]);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_reports.size();
    compared_o   <= compared;
    accepted_o   <= accepted;
  end

endmodule

// ===== tb/quadrature_position_speed_with_homing_tb.sv =====
// testbench top for the quadrature counter: stimulus, stalls, watchdog and verdict
module quadrature_position_speed_with_homing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [qpsh_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // level_a, level_b, pad
  logic [qpsh_pkg::REQ_W-1:0]      s_tuser = '0;   // req_type
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [qpsh_pkg::OUT_DATA_W-1:0] m_tdata;        // report_value, pulse_total, motion_code, pad
  logic                            m_tuser;        // report_kind
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [qpsh_pkg::ADDR_W-1:0]     paddr = '0;
  logic [qpsh_pkg::APB_W-1:0]      pwdata = '0;
  logic [qpsh_pkg::APB_W-1:0]      prdata;
  logic                            pready;

  logic gaps_on = 1'b1;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   config_writes = 0;
  int   fail_count;
  int   pending;
  int   compared;
  int   accepted;

  always #5ns clk_i = ~clk_i;

  quadrature_position_speed_with_homing u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  quadrature_report_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .compared_o      (compared),
    .accepted_o      (accepted)
  );

  // result side stalls for a random number of cycles after each transfer while gaps_on is set
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) begin
      stall_left = gaps_on ? $urandom_range(0, 7) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    m_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic [qpsh_pkg::REQ_W-1:0] req, logic a, logic b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {{(qpsh_pkg::IN_DATA_W - 2){1'b0}}, b, a};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic apb_access(logic wr, logic [1:0] idx, logic [qpsh_pkg::APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper bits of the write data are junk, only the low half is kept
  task automatic write_reg(logic [1:0] idx, logic [qpsh_pkg::CFG_W-1:0] value);
    apb_access(1'b1, idx, {16'($urandom), value});
    config_writes++;
    if (idx != REG_UNUSED) apb_access(1'b0, idx, '0);
  endtask

  task automatic flush_reports();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    flush_reports();
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned bias;
    int unsigned pick;
    logic        a;
    logic        up;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, qpsh_pkg::REG_PERIOD, '0);
    apb_access(1'b0, qpsh_pkg::REG_UM, '0);
    apb_access(1'b0, qpsh_pkg::REG_SCALE, '0);
    write_reg(qpsh_pkg::REG_UM, 16'hffff);

    // before homing: edges count, ticks and an unarmed second stop do nothing
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_TICK, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_SECOND, 1'b0, 1'b1);
    // armed, count driven negative, repeated first stop and ticks ignored
    send_item(qpsh_pkg::REQ_FIRST, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b1);
    send_item(qpsh_pkg::REQ_FIRST, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_SECOND, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_SECOND, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_FIRST, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b1);
    send_item(qpsh_pkg::REQ_TICK, 1'b1, 1'b1);

    wait_idle();
    write_reg(qpsh_pkg::REG_PERIOD, 16'd1);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b0);
    send_item(qpsh_pkg::REQ_EDGE, 1'b0, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_TICK, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b1);

    // zero period behaves as one
    wait_idle();
    write_reg(qpsh_pkg::REG_PERIOD, 16'd0);
    send_item(qpsh_pkg::REQ_TICK, 1'b1, 1'b1);
    send_item(qpsh_pkg::REQ_EDGE, 1'b1, 1'b0);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b0);

    // long window, then shrink it below the elapsed time
    wait_idle();
    write_reg(qpsh_pkg::REG_SCALE, 16'hffff);
    write_reg(qpsh_pkg::REG_PERIOD, 16'hffff);
    for (int i = 0; i < 14; i++) begin
      a = 1'($urandom_range(0, 1));
      if (i % 2 == 0) send_item(qpsh_pkg::REQ_EDGE, a, 1'($urandom_range(0, 1)));
      else send_item(qpsh_pkg::REQ_TICK, a, ~a);
    end
    wait_idle();
    write_reg(qpsh_pkg::REG_PERIOD, 16'd3);
    send_item(qpsh_pkg::REQ_TICK, 1'b0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      gaps_on <= (ph % 3 != 2);
      case (ph % 4)
        0:       write_reg(qpsh_pkg::REG_PERIOD, 16'($urandom_range(1, 3)));
        1:       write_reg(qpsh_pkg::REG_PERIOD, 16'($urandom_range(4, 12)));
        2:       write_reg(qpsh_pkg::REG_PERIOD, 16'($urandom_range(20, 60)));
        default: write_reg(qpsh_pkg::REG_PERIOD, 16'd1);
      endcase
      case (ph)
        1:       write_reg(qpsh_pkg::REG_SCALE, 16'd1);
        2:       write_reg(qpsh_pkg::REG_SCALE, 16'hffff);
        default: write_reg(qpsh_pkg::REG_SCALE, 16'($urandom_range(1, 65535)));
      endcase
      if (ph == 3) write_reg(qpsh_pkg::REG_UM, 16'd1);
      if (ph == 4) write_reg(REG_UNUSED, 16'($urandom));
      if (ph == 6) write_reg(qpsh_pkg::REG_UM, 16'($urandom_range(1, 65535)));
      case (ph % 3)
        0:       bias = 10;
        1:       bias = 50;
        default: bias = 90;
      endcase
      for (int i = 0; i < 115; i++) begin
        if (ph == 4 && i == 57) flush_reports();
        pick = $urandom_range(0, 99);
        a    = 1'($urandom_range(0, 1));
        up   = ($urandom_range(0, 99) < bias);
        if (pick < 72) send_item(qpsh_pkg::REQ_EDGE, a, up ? ~a : a);
        else if (pick < 95) send_item(qpsh_pkg::REQ_TICK, a, 1'($urandom_range(0, 1)));
        else if (pick < 97) send_item(qpsh_pkg::REQ_FIRST, a, 1'($urandom_range(0, 1)));
        else send_item(qpsh_pkg::REQ_SECOND, a, 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    $display("covered %0d input items under %0d register writes: homing, windows 0 to 65535",
             accepted, config_writes);
    $display("%0d rope length and speed reports compared field by field", compared);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
